### src/lsc_pkg.sv
package lsc_pkg;

	localparam int unsigned SLOTS_DEF = 12;

	localparam int unsigned ID_W     = 7;
	localparam int unsigned SLOT_W   = 4;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned STAMP_W  = 32;
	localparam int unsigned IN_TDATA_W  = 8;
	localparam int unsigned OUT_TDATA_W = 8;

	localparam logic [STAMP_W-1:0] AGE_LIMIT = 32'hffff_fffe;
	localparam logic [STAMP_W-1:0] STAMP_MAX = 32'hffff_ffff;
	localparam logic [STAMP_W-1:0] AGE_RESET = 32'h0000_0001;

	typedef enum logic [STATUS_W-1:0] {
		ST_HIT      = 2'd0,
		ST_MISS     = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef struct packed {
		logic start;
		logic cmp_en;
	} scan_ctrl_t;

	typedef struct packed {
		logic hit;
		logic done;
	} scan_stat_t;

endpackage

### src/lsc_ram.sv
module lsc_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### src/lsc_scan.sv
module lsc_scan
	import lsc_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  scan_ctrl_t               ctrl,
	input  logic [$clog2(SLOTS)-1:0] idx,
	input  logic [ID_W-1:0]          id,
	input  logic                     ent_valid,
	input  logic [ID_W-1:0]          ent_tag,
	input  logic [STAMP_W-1:0]       ent_stamp,
	output scan_stat_t               stat,
	output logic [$clog2(SLOTS)-1:0] tgt_idx
);

	localparam int unsigned IDX_W = $clog2(SLOTS);

	logic [STAMP_W-1:0] best_stamp_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic [STAMP_W-1:0] stamp_eff;
	logic               better;
	logic [IDX_W-1:0]   best_idx_nxt;

	// empty slots count as stamp zero
	assign stamp_eff    = ent_valid ? ent_stamp : '0;
	assign better       = stamp_eff < best_stamp_q;
	assign best_idx_nxt = better ? idx : best_idx_q;

	assign stat.hit  = ctrl.cmp_en && ent_valid && (ent_tag == id);
	assign stat.done = ctrl.cmp_en && (stat.hit || idx == IDX_W'(SLOTS - 1));
	assign tgt_idx   = stat.hit ? idx : best_idx_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_stamp_q <= STAMP_MAX;
			best_idx_q   <= '0;
		end else if (ctrl.start) begin
			best_stamp_q <= STAMP_MAX;
			best_idx_q   <= '0;
		end else if (ctrl.cmp_en && better) begin
			best_stamp_q <= stamp_eff;
			best_idx_q   <= idx;
		end
	end

endmodule

### src/lru_slot_cache.sv
// channel  dir  tdata (low bit up)                 handshake
// s_axis   in   sound_id[6:0], pad[7]              s_tvalid / s_tready
// m_axis   out  slot[3:0], status[5:4], pad[7:6]   m_tvalid / m_tready
//
// a request goes from accept through the scan state, the write state and the done state to the result;
// the scan reads one slot per cycle from the tag/stamp ram;
// a hit ends the scan early, an age overflow skips the scan and the write and goes straight to done
// reset empties all slots at once and sets the age counter to one
// one request is handled at a time: s_tready rises again as the result is registered;
// a result waiting on m_tready holds the next one back at its last step
module lru_slot_cache
	import lsc_pkg::*;
#(
	parameter int unsigned SLOTS = SLOTS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // sound_id
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata   // slot, status
);

	localparam int unsigned IDX_W = $clog2(SLOTS);
	localparam int unsigned CNT_W = $clog2(SLOTS + 1);
	localparam int unsigned ENT_W = ID_W + STAMP_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_WRITE,
		S_DONE
	} state_t;

	state_t             state_q;
	logic [ID_W-1:0]    id_q;
	logic [STAMP_W-1:0] age_q;
	logic [SLOTS-1:0]   valid_q;
	logic [CNT_W-1:0]   rd_cnt_q;
	logic               cmp_vld_s1;
	logic [IDX_W-1:0]   cmp_idx_s1;
	logic [IDX_W-1:0]   tgt_q;
	logic [SLOT_W-1:0]  res_slot_q;
	status_t            res_status_q;
	logic               m_tvalid_q;
	logic [SLOT_W-1:0]  m_slot_q;
	status_t            m_status_q;

	logic               accept;
	logic               out_free;
	logic [IDX_W-1:0]   rd_addr;
	logic [IDX_W-1:0]   ram_addr;
	logic               ram_we;
	logic [ENT_W-1:0]   ram_wdata;
	logic [ENT_W-1:0]   ram_rdata;
	scan_ctrl_t         scan_ctrl;
	scan_stat_t         scan_stat;
	logic [IDX_W-1:0]   scan_tgt;
	logic [SLOT_W+IDX_W-1:0] tgt_ext;

	assign accept   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == S_IDLE);
	assign rd_addr  = rd_cnt_q[IDX_W-1:0];
	assign ram_we   = (state_q == S_WRITE);
	assign ram_addr = ram_we ? tgt_q : rd_addr;
	assign ram_wdata = {id_q, age_q};
	assign tgt_ext  = {{SLOT_W{1'b0}}, tgt_q};

	assign scan_ctrl.start  = accept;
	assign scan_ctrl.cmp_en = (state_q == S_SCAN) && cmp_vld_s1;

	lsc_ram #(
		.WIDTH(ENT_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(ram_wdata),
		.rdata(ram_rdata)
	);

	lsc_scan #(
		.SLOTS(SLOTS)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (scan_ctrl),
		.idx      (cmp_idx_s1),
		.id       (id_q),
		.ent_valid(valid_q[cmp_idx_s1]),
		.ent_tag  (ram_rdata[ENT_W-1:STAMP_W]),
		.ent_stamp(ram_rdata[STAMP_W-1:0]),
		.stat     (scan_stat),
		.tgt_idx  (scan_tgt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			id_q         <= '0;
			age_q        <= AGE_RESET;
			valid_q      <= '0;
			rd_cnt_q     <= '0;
			cmp_vld_s1   <= 1'b0;
			cmp_idx_s1   <= '0;
			tgt_q        <= '0;
			res_slot_q   <= '0;
			res_status_q <= ST_HIT;
			m_tvalid_q   <= 1'b0;
			m_slot_q     <= '0;
			m_status_q   <= ST_HIT;
		end else begin
			if (m_tvalid_q && m_tready && state_q != S_DONE) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						id_q <= s_tdata[ID_W-1:0];
						if (age_q == AGE_LIMIT) begin
							res_slot_q   <= '0;
							res_status_q <= ST_OVERFLOW;
							state_q      <= S_DONE;
						end else begin
							rd_cnt_q   <= '0;
							cmp_vld_s1 <= 1'b0;
							state_q    <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (scan_stat.done) begin
						tgt_q        <= scan_tgt;
						res_status_q <= scan_stat.hit ? ST_HIT : ST_MISS;
						cmp_vld_s1   <= 1'b0;
						state_q      <= S_WRITE;
					end else if (rd_cnt_q != CNT_W'(SLOTS)) begin
						rd_cnt_q   <= rd_cnt_q + 1'b1;
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= rd_addr;
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
				end
				S_WRITE: begin
					valid_q[tgt_q] <= 1'b1;
					age_q          <= age_q + 1'b1;
					res_slot_q     <= tgt_ext[SLOT_W-1:0];
					state_q        <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						m_slot_q   <= res_slot_q;
						m_status_q <= res_status_q;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{(OUT_TDATA_W - SLOT_W - STATUS_W){1'b0}}, m_status_q, m_slot_q};

endmodule

### dv/lru_slot_cache_tb.sv
module lru_slot_cache_tb
	import lsc_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAND_REQS   = 700;
	localparam int CALM_TAIL   = 100;
	localparam int CYCLE_LIMIT = 200000;
	localparam int DIR_ROWS    = 17;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} lookup_res_t;

	typedef struct packed {
		logic [ID_W-1:0]   id;
		logic              typed;
		logic [SLOT_W-1:0] slot;
		status_t           status;
	} dir_row_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // sound_id[6:0], pad[7]
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // slot[3:0], status[5:4], pad[7:6]

	logic                   slot_used [SLOTS_DEF];
	logic [ID_W-1:0]        slot_id   [SLOTS_DEF];
	logic [STAMP_W-1:0]     slot_age  [SLOTS_DEF];
	logic [STAMP_W-1:0]     age_ctr;

	lookup_res_t            expected_lookups [$];
	int unsigned            mismatches;
	int unsigned            cycles;
	bit                     idle_on;

	dir_row_t dir_reqs [DIR_ROWS] = '{
		'{7'd0,   1'b1, 4'd0,  ST_MISS},
		'{7'd127, 1'b1, 4'd1,  ST_MISS},
		'{7'd0,   1'b1, 4'd0,  ST_HIT},
		'{7'd1,   1'b1, 4'd2,  ST_MISS},
		'{7'd2,   1'b1, 4'd3,  ST_MISS},
		'{7'd3,   1'b1, 4'd4,  ST_MISS},
		'{7'd4,   1'b1, 4'd5,  ST_MISS},
		'{7'd5,   1'b1, 4'd6,  ST_MISS},
		'{7'd6,   1'b1, 4'd7,  ST_MISS},
		'{7'd7,   1'b1, 4'd8,  ST_MISS},
		'{7'd8,   1'b1, 4'd9,  ST_MISS},
		'{7'd9,   1'b1, 4'd10, ST_MISS},
		'{7'd10,  1'b1, 4'd11, ST_MISS},
		'{7'd85,  1'b1, 4'd1,  ST_MISS},
		'{7'd127, 1'b1, 4'd0,  ST_MISS},
		'{7'd42,  1'b0, 4'd0,  ST_HIT},
		'{7'd85,  1'b0, 4'd0,  ST_HIT}
	};

	lru_slot_cache DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic void clear_cache();
		for (int i = 0; i < SLOTS_DEF; i++) begin
			slot_used[i] = 1'b0;
			slot_id[i]   = '0;
			slot_age[i]  = '0;
		end
		age_ctr = AGE_RESET;
	endfunction

	function automatic lookup_res_t lru_lookup(input logic [ID_W-1:0] id);
		lookup_res_t        res;
		int                 victim;
		logic [STAMP_W-1:0] oldest;
		res.slot   = '0;
		res.status = ST_OVERFLOW;
		if (age_ctr == AGE_LIMIT)
			return res;
		victim = 0;
		oldest = STAMP_MAX;
		for (int i = 0; i < SLOTS_DEF; i++) begin
			if (slot_used[i] && slot_id[i] == id) begin
				slot_age[i] = age_ctr;
				age_ctr++;
				res.slot   = SLOT_W'(i);
				res.status = ST_HIT;
				return res;
			end
			if (slot_age[i] < oldest) begin
				oldest = slot_age[i];
				victim = i;
			end
		end
		slot_used[victim] = 1'b1;
		slot_id[victim]   = id;
		slot_age[victim]  = age_ctr;
		age_ctr++;
		res.slot   = SLOT_W'(victim);
		res.status = ST_MISS;
		return res;
	endfunction

	task automatic send_request(input logic [ID_W-1:0] id, input logic typed,
			input lookup_res_t typed_res);
		lookup_res_t res;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, id};
		do @(posedge clk); while (!s_tready);
		res = lru_lookup(id);
		expected_lookups.push_back(typed ? typed_res : res);
	endtask

	task automatic maybe_gap();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 5)) @(negedge clk);
		end
	endtask

	task automatic drain_lookups();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_lookups.size() != 0) @(posedge clk);
	endtask

	// receiver stalls
	initial begin
		int stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(1, 6) - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// result checker
	initial begin
		lookup_res_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				if (expected_lookups.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word: slot %0d status %0d",
							m_tdata[3:0], m_tdata[5:4]);
				end else begin
					want = expected_lookups.pop_front();
					if (m_tdata[3:0] !== want.slot || m_tdata[5:4] !== want.status) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected slot %0d status %0d, got slot %0d status %0d",
								want.slot, want.status, m_tdata[3:0], m_tdata[5:4]);
					end
				end
			end
		end
	end

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [ID_W-1:0] id;
		int              pool_base;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		mismatches = 0;
		idle_on    = 1'b1;
		pool_base  = 0;
		clear_cache();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int r = 0; r < DIR_ROWS; r++) begin
			maybe_gap();
			send_request(dir_reqs[r].id, dir_reqs[r].typed,
				{dir_reqs[r].slot, dir_reqs[r].status});
		end
		drain_lookups();

		for (int n = 0; n < RAND_REQS; n++) begin
			idle_on = (n < RAND_REQS - CALM_TAIL) && (n % 150 < 110);
			if (n % 80 == 0)
				pool_base = $urandom_range(0, 113);
			if (n == RAND_REQS / 2)
				drain_lookups();
			// mostly a working set a little larger than the cache
			if ($urandom_range(0, 9) < 7)
				id = ID_W'(pool_base + $urandom_range(0, 13));
			else
				id = ID_W'($urandom_range(0, 127));
			maybe_gap();
			send_request(id, 1'b0, '0);
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		while (expected_lookups.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		if (mismatches == 0 && expected_lookups.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
